// ----- rtl/tmrp_pkg.sv -----
// Shared types and constants for the terminal mouse report parser.
package tmrp_pkg;

    // Report formats selected by the configuration register.
    typedef enum logic [1:0] {
        FMT_DEFAULT = 2'd0,
        FMT_UTF8    = 2'd1,
        FMT_SGR     = 2'd2,
        FMT_DECIMAL = 2'd3
    } t_format;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ESC      = 4'd1,
        PH_CSI      = 4'd2,
        PH_RAW_B    = 4'd3,
        PH_RAW_C    = 4'd4,
        PH_RAW_R    = 4'd5,
        PH_DB_FIRST = 4'd6,
        PH_DB_MORE  = 4'd7,
        PH_DC_FIRST = 4'd8,
        PH_DC_MORE  = 4'd9,
        PH_DR_FIRST = 4'd10,
        PH_DR_MORE  = 4'd11
    } t_phase;

    // Character codes.
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_UPPER_M  = 8'h4D;
    localparam logic [7:0] CH_LOWER_M  = 8'h6D;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    // Field offsets and substitutes for a zero column or row.
    localparam logic [20:0] RAW_OFFSET   = 21'd32;
    localparam logic [20:0] ZSUB_DEFAULT = 21'd224;
    localparam logic [20:0] ZSUB_UTF8    = 21'd2015;
    localparam logic [15:0] DEC_OFFSET   = 16'd32;

    localparam logic [3:0] BTN_NONE = 4'd3;

    localparam int QUEUE_DEPTH_DEF = 4;

    // One parsed report on its way from the parser to the decoder.
    typedef struct packed {
        logic [7:0]  button_code;
        logic [20:0] column;
        logic [20:0] line;
        logic        sgr_release;
    } t_report;

endpackage

// ----- rtl/tmrp_front.sv -----
// Byte parser: tracks the escape sequence and collects the report fields.
module tmrp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    output logic               o_push,
    output tmrp_pkg::t_report  o_report
);
    import tmrp_pkg::*;

    t_format     r_format;
    t_phase      r_phase,  n_phase;
    logic [20:0] r_acc,    n_acc;
    logic [1:0]  r_rem,    n_rem;
    logic [7:0]  r_button, n_button;
    logic [20:0] r_column, n_column;
    logic [20:0] r_line,   n_line;

    t_phase      eff_phase;
    logic        is_digit;
    logic [3:0]  digit;
    logic [15:0] acc16;
    logic [15:0] dec_next;
    logic [20:0] utf_next;
    logic        take;
    logic [20:0] take_val;
    logic [20:0] dval;
    logic [20:0] zsub;
    logic        restart;
    logic        emit;
    logic        term_rel;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = i_byte[3:0];
    assign acc16    = r_acc[15:0];
    // Times ten as two shifted adds, wrapping at 16 bits.
    assign dec_next = {acc16[12:0], 3'b000} + {acc16[14:0], 1'b0} + {12'd0, digit};
    assign utf_next = {r_acc[14:0], i_byte[5:0]};
    assign zsub     = (r_format == FMT_DEFAULT) ? ZSUB_DEFAULT : ZSUB_UTF8;

    // The decimal format has no introducer, so its first byte after the
    // bracket is handled as the first digit of the button value.
    assign eff_phase = (r_phase == PH_CSI && r_format == FMT_DECIMAL) ? PH_DB_FIRST : r_phase;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_button = r_button;
        n_column = r_column;
        n_line   = r_line;
        take     = 1'b0;
        take_val = '0;
        dval     = '0;
        restart  = 1'b0;
        emit     = 1'b0;
        term_rel = 1'b0;

        if (i_valid) begin
            case (eff_phase)
                PH_ESC: begin
                    if (i_byte == CH_LBRACKET) n_phase = PH_CSI;
                    else restart = 1'b1;
                end
                PH_CSI: begin
                    if (r_format == FMT_SGR) begin
                        if (i_byte == CH_LT) n_phase = PH_DB_FIRST;
                        else restart = 1'b1;
                    end else begin
                        if (i_byte == CH_UPPER_M) n_phase = PH_RAW_B;
                        else restart = 1'b1;
                    end
                end
                PH_RAW_B, PH_RAW_C, PH_RAW_R: begin
                    if (r_format == FMT_DEFAULT) begin
                        take     = 1'b1;
                        take_val = {13'd0, i_byte};
                    end else if (r_format != FMT_UTF8) begin
                        restart = 1'b1;
                    end else if (r_rem == 2'd0) begin
                        if (!i_byte[7]) begin
                            take     = 1'b1;
                            take_val = {13'd0, i_byte};
                        end else if (i_byte[7:5] == 3'b110) begin
                            n_acc = {16'd0, i_byte[4:0]};
                            n_rem = 2'd1;
                        end else if (i_byte[7:4] == 4'b1110) begin
                            n_acc = {17'd0, i_byte[3:0]};
                            n_rem = 2'd2;
                        end else if (i_byte[7:3] == 5'b11110) begin
                            n_acc = {18'd0, i_byte[2:0]};
                            n_rem = 2'd3;
                        end else begin
                            restart = 1'b1;
                        end
                    end else if (i_byte[7:6] != 2'b10) begin
                        restart = 1'b1;
                    end else begin
                        n_acc = utf_next;
                        n_rem = r_rem - 2'd1;
                        if (r_rem == 2'd1) begin
                            take     = 1'b1;
                            take_val = utf_next;
                        end
                    end
                end
                PH_DB_FIRST, PH_DC_FIRST, PH_DR_FIRST: begin
                    if (r_format == FMT_DEFAULT || r_format == FMT_UTF8 || !is_digit) begin
                        restart = 1'b1;
                    end else begin
                        n_acc   = {17'd0, digit};
                        n_phase = t_phase'(eff_phase + 4'd1);
                    end
                end
                PH_DB_MORE, PH_DC_MORE, PH_DR_MORE: begin
                    if (r_format == FMT_DEFAULT || r_format == FMT_UTF8) begin
                        restart = 1'b1;
                    end else if (is_digit) begin
                        n_acc = {5'd0, dec_next};
                    end else if (eff_phase == PH_DB_MORE) begin
                        if (i_byte == CH_SEMI) begin
                            n_button = (r_format == FMT_DECIMAL) ?
                                       8'(acc16 - DEC_OFFSET) : acc16[7:0];
                            n_phase  = PH_DC_FIRST;
                        end else begin
                            restart = 1'b1;
                        end
                    end else if (eff_phase == PH_DC_MORE) begin
                        if (i_byte == CH_SEMI) begin
                            n_column = {5'd0, acc16};
                            n_phase  = PH_DR_FIRST;
                        end else begin
                            restart = 1'b1;
                        end
                    end else begin
                        n_line = {5'd0, acc16};
                        if (i_byte == CH_UPPER_M) begin
                            emit = 1'b1;
                        end else if (i_byte == CH_LOWER_M && r_format == FMT_SGR) begin
                            emit     = 1'b1;
                            term_rel = 1'b1;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                end
                default: begin
                    restart = 1'b1;
                end
            endcase

            // A complete raw or UTF-8 field value.
            if (take) begin
                n_acc = '0;
                n_rem = 2'd0;
                if (r_phase == PH_RAW_B) begin
                    if (take_val < RAW_OFFSET) begin
                        restart = 1'b1;
                    end else begin
                        n_button = 8'(take_val - RAW_OFFSET);
                        n_phase  = PH_RAW_C;
                    end
                end else begin
                    if (take_val == '0) begin
                        dval = zsub;
                    end else if (take_val > RAW_OFFSET) begin
                        dval = take_val - RAW_OFFSET;
                    end else begin
                        restart = 1'b1;
                    end
                    if (!restart) begin
                        if (r_phase == PH_RAW_C) begin
                            n_column = dval;
                            n_phase  = PH_RAW_R;
                        end else begin
                            n_line = dval;
                            emit   = 1'b1;
                        end
                    end
                end
            end

            if (restart) begin
                n_phase = (i_byte == CH_ESC) ? PH_ESC : PH_IDLE;
                n_acc   = '0;
                n_rem   = 2'd0;
            end else if (emit) begin
                n_phase = PH_IDLE;
                n_acc   = '0;
                n_rem   = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_DEFAULT;
            r_phase  <= PH_IDLE;
            r_acc    <= '0;
            r_rem    <= 2'd0;
            r_button <= '0;
            r_column <= '0;
            r_line   <= '0;
        end else if (i_cfg_we) begin
            r_format <= t_format'(i_cfg_wdata);
            r_phase  <= PH_IDLE;
            r_acc    <= '0;
            r_rem    <= 2'd0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_button <= n_button;
            r_column <= n_column;
            r_line   <= n_line;
        end
    end

    assign o_push               = emit && !i_cfg_we;
    assign o_report.button_code = n_button;
    assign o_report.column      = n_column;
    assign o_report.line        = n_line;
    assign o_report.sgr_release = term_rel;

    // A finished report always sends the parser back to idle.
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_phase == PH_IDLE && r_rem == 2'd0))
        else $error("parser did not return to idle after a report");

endmodule

// ----- rtl/tmrp_queue.sv -----
// Short report queue between the parser and the event decoder.
module tmrp_queue #(
    parameter int DEPTH = tmrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tmrp_pkg::t_report i_data,
    output logic              o_full,
    input  logic              i_pop,
    output tmrp_pkg::t_report o_data,
    output logic              o_empty
);
    import tmrp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    t_report       r_entry [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULLC);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            if (do_pop)  r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CW'(1);
        end
    end

    // The parser must never finish a report while the queue is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("report pushed into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULLC)
        else $error("queue count beyond depth");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("queue count did not drop on a pop");

endmodule

// ----- rtl/tmrp_back.sv -----
// Event decoder with the output register that holds the oldest event.
module tmrp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  tmrp_pkg::t_report i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [3:0]        o_button,
    output logic              o_shift_key,
    output logic              o_alt_key,
    output logic              o_control_key,
    output logic              o_moving,
    output logic              o_release_res,
    output logic              o_held,
    output logic [20:0]       o_column,
    output logic [20:0]       o_line
);
    import tmrp_pkg::*;

    logic        r_valid;
    logic [3:0]  n_button;
    logic        n_release;
    logic        n_held;
    logic [7:0]  code;
    logic        load;

    assign code = i_q_data.button_code;

    always_comb begin
        if (code[7])      n_button = {2'b10, code[1:0]};
        else if (code[6]) n_button = {2'b01, code[1:0]};
        else              n_button = {2'b00, code[1:0]};
        n_release = i_q_data.sgr_release || (n_button == BTN_NONE && !code[5]);
        n_held    = !n_release && (n_button < BTN_NONE);
    end

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load;
    assign o_empty = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_button      <= n_button;
            o_shift_key   <= code[2];
            o_alt_key     <= code[3];
            o_control_key <= code[4];
            o_moving      <= code[5];
            o_release_res <= n_release;
            o_held        <= n_held;
            o_column      <= i_q_data.column;
            o_line        <= i_q_data.line;
        end
    end

endmodule

// ----- rtl/terminal_mouse_report_parser.sv -----
// Top level of the terminal mouse report parser.
//
//  Channel   Handshake            Payload                          Direction
//  -------   ------------------   ------------------------------   ---------
//  bytes     push / full          i_byte_req                       in
//  events    empty / pop          o_button .. o_line               out
//  config    i_cfg_we             i_cfg_wdata (report format)      in
//
// Every input beat is parsed in the cycle it is accepted, so bytes can be
// pushed on every clock while full is low. A finished report is written to
// the report queue when its last byte is accepted, and then moves on to the
// output register once that register is free; empty falls when it is loaded.
// Reset is synchronous and active low; it empties the queue and the output
// register and selects the default format.
// full follows the report queue: it rises only when the queue holds QUEUE_DEPTH
// reports, which happens only after the event side has stopped popping.
module terminal_mouse_report_parser #(
    parameter int QUEUE_DEPTH = tmrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_req,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_button,
    output logic        o_shift_key,
    output logic        o_alt_key,
    output logic        o_control_key,
    output logic        o_moving,
    output logic        o_release_res,
    output logic        o_held,
    output logic [20:0] o_column,
    output logic [20:0] o_line,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);
    import tmrp_pkg::*;

    logic    byte_valid;
    logic    rep_push;
    t_report rep_in;
    logic    q_full;
    logic    q_pop;
    t_report q_data;
    logic    q_empty;

    // A beat is taken whenever the queue has room; the parser never stalls a byte.
    assign full       = q_full;
    assign byte_valid = push && !q_full;

    // Front: escape sequence tracking and field collection.
    tmrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (byte_valid),
        .i_byte      (i_byte_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (rep_push),
        .o_report    (rep_in)
    );

    // Decouples the parser from a stalled event consumer.
    tmrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rep_push),
        .i_data  (rep_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    // Back: turns the button code into flags and holds the event for pop.
    tmrp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_button      (o_button),
        .o_shift_key   (o_shift_key),
        .o_alt_key     (o_alt_key),
        .o_control_key (o_control_key),
        .o_moving      (o_moving),
        .o_release_res (o_release_res),
        .o_held        (o_held),
        .o_column      (o_column),
        .o_line        (o_line)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the terminal mouse report parser.
`timescale 1ns / 1ps

module tb_top;

    import tmrp_pkg::*;

    // One decoded mouse event, as the block presents it on its result ports.
    typedef struct {
        logic [3:0]  button;
        logic        shift_key;
        logic        alt_key;
        logic        control_key;
        logic        moving;
        logic        release_res;
        logic        held;
        logic [20:0] column;
        logic [20:0] line;
    } t_mouse_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_byte_req;
    logic        empty;
    logic        pop;
    logic [3:0]  o_button;
    logic        o_shift_key;
    logic        o_alt_key;
    logic        o_control_key;
    logic        o_moving;
    logic        o_release_res;
    logic        o_held;
    logic [20:0] o_column;
    logic [20:0] o_line;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_wdata;

    // Events the byte stream has produced so far and that have not been popped yet.
    t_mouse_event pending_events[$];
    // Bytes of the sequence being assembled before it is streamed into the block.
    logic [7:0]   frame[$];

    int error_count       = 0;
    int bytes_sent        = 0;
    // When set, the sender or the receiver runs back to back with no idle cycles.
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    // Shadow copy of the parser: selected format, phase and the partial report.
    t_format     sel_format;
    t_phase      phase_q;
    logic [15:0] code_word;
    logic [20:0] col_held;
    logic [20:0] row_held;
    logic [20:0] value_acc;
    logic [1:0]  cont_left;

    terminal_mouse_report_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_byte_req    (i_byte_req),
        .empty         (empty),
        .pop           (pop),
        .o_button      (o_button),
        .o_shift_key   (o_shift_key),
        .o_alt_key     (o_alt_key),
        .o_control_key (o_control_key),
        .o_moving      (o_moving),
        .o_release_res (o_release_res),
        .o_held        (o_held),
        .o_column      (o_column),
        .o_line        (o_line),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------

    // A byte that breaks the report in progress drops the parser back to idle,
    // and the same byte is looked at again as the start of a new sequence.
    task automatic restart_at(input logic [7:0] b);
        phase_q   = (b == CH_ESC) ? PH_ESC : PH_IDLE;
        cont_left = '0;
        value_acc = '0;
    endtask

    // Decode the collected button code and queue the event.
    task automatic finish_report(input bit sgr_up);
        t_mouse_event ev;
        logic [3:0]   code;
        logic         rel;
        code = {2'b00, code_word[1:0]};
        if (code_word[7]) begin
            code = code | 4'd8;
        end else if (code_word[6]) begin
            code = code | 4'd4;
        end
        rel = sgr_up || (code == BTN_NONE && !code_word[5]);
        ev.button      = code;
        ev.shift_key   = code_word[2];
        ev.alt_key     = code_word[3];
        ev.control_key = code_word[4];
        ev.moving      = code_word[5];
        ev.release_res = rel;
        ev.held        = !rel && (code < BTN_NONE);
        ev.column      = col_held;
        ev.line        = row_held;
        pending_events.push_back(ev);
        phase_q   = PH_IDLE;
        cont_left = '0;
        value_acc = '0;
    endtask

    // One complete field of a raw or multibyte report.
    task automatic take_field(input logic [20:0] v, input logic [20:0] zero_sub,
                              input logic [7:0] b);
        logic [20:0] d;
        value_acc = '0;
        cont_left = '0;
        if (phase_q == PH_RAW_B) begin
            if (v < RAW_OFFSET) begin
                restart_at(b);
            end else begin
                code_word = v[15:0] - 16'd32;
                phase_q   = PH_RAW_C;
            end
        end else begin
            if (v == '0) begin
                d = zero_sub;
            end else if (v > RAW_OFFSET) begin
                d = v - RAW_OFFSET;
            end else begin
                // Column and row values from 1 to 32 cannot be encoded.
                restart_at(b);
                return;
            end
            if (phase_q == PH_RAW_C) begin
                col_held = d;
                phase_q  = PH_RAW_R;
            end else begin
                row_held = d;
                finish_report(1'b0);
            end
        end
    endtask

    task automatic parse_raw(input logic [7:0] b);
        if (sel_format == FMT_DEFAULT) begin
            take_field({13'd0, b}, ZSUB_DEFAULT, b);
        end else if (sel_format != FMT_UTF8) begin
            restart_at(b);
        end else if (cont_left == 2'd0) begin
            // Lead byte: plain ASCII, or the start of a 2, 3 or 4 byte character.
            if (b < 8'h80) begin
                take_field({13'd0, b}, ZSUB_UTF8, b);
            end else if ((b & 8'hE0) == 8'hC0) begin
                value_acc = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
                value_acc = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
                value_acc = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end else begin
                restart_at(b);
            end
        end else if ((b & 8'hC0) != 8'h80) begin
            restart_at(b);
        end else begin
            value_acc = {value_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                take_field(value_acc, ZSUB_UTF8, b);
            end
        end
    endtask

    task automatic parse_digit(input logic [7:0] b);
        bit is_digit;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        if (sel_format == FMT_DEFAULT || sel_format == FMT_UTF8) begin
            restart_at(b);
        end else if (phase_q == PH_DB_FIRST || phase_q == PH_DC_FIRST ||
                     phase_q == PH_DR_FIRST) begin
            // Every decimal value has to start with a digit.
            if (!is_digit) begin
                restart_at(b);
            end else begin
                value_acc = {13'd0, b - CH_ZERO};
                phase_q   = t_phase'(phase_q + 4'd1);
            end
        end else if (is_digit) begin
            // Decimal values wrap at 16 bits.
            value_acc = ((value_acc * 21'd10) + {13'd0, b - CH_ZERO}) & 21'h00FFFF;
        end else if (phase_q == PH_DB_MORE) begin
            if (b != CH_SEMI) begin
                restart_at(b);
            end else begin
                code_word = (sel_format == FMT_DECIMAL) ? value_acc[15:0] - DEC_OFFSET
                                                        : value_acc[15:0];
                phase_q   = PH_DC_FIRST;
            end
        end else if (phase_q == PH_DC_MORE) begin
            if (b != CH_SEMI) begin
                restart_at(b);
            end else begin
                col_held = {5'd0, value_acc[15:0]};
                phase_q  = PH_DR_FIRST;
            end
        end else begin
            row_held = {5'd0, value_acc[15:0]};
            if (b == CH_UPPER_M) begin
                finish_report(1'b0);
            end else if (b == CH_LOWER_M && sel_format == FMT_SGR) begin
                finish_report(1'b1);
            end else begin
                restart_at(b);
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        case (phase_q)
            PH_ESC: begin
                if (b == CH_LBRACKET) phase_q = PH_CSI;
                else restart_at(b);
            end
            PH_CSI: begin
                if (sel_format == FMT_DECIMAL) begin
                    // No introducer: the first byte already belongs to the button.
                    phase_q = PH_DB_FIRST;
                    parse_digit(b);
                end else if (sel_format == FMT_SGR) begin
                    if (b == CH_LT) phase_q = PH_DB_FIRST;
                    else restart_at(b);
                end else begin
                    if (b == CH_UPPER_M) phase_q = PH_RAW_B;
                    else restart_at(b);
                end
            end
            PH_RAW_B, PH_RAW_C, PH_RAW_R: begin
                parse_raw(b);
            end
            PH_DB_FIRST, PH_DB_MORE, PH_DC_FIRST, PH_DC_MORE, PH_DR_FIRST, PH_DR_MORE: begin
                parse_digit(b);
            end
            default: begin
                restart_at(b);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // Push one byte. The idle gap is drawn per beat; push stays high when the
    // next beat follows at once, so it is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_byte_req <= b;
        do @(posedge i_clk); while (full);
        bytes_sent++;
        predict_byte(b);
    endtask

    task automatic send_frame();
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    // Stop pushing and let every predicted event come out. The path to the output
    // runs through the report queue and the output register, so a closing wait
    // covers a report still in flight that has no expectation of its own.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_format(input t_format f);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= f;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        // A write abandons any report in progress.
        sel_format = f;
        phase_q    = PH_IDLE;
        cont_left  = '0;
        value_acc  = '0;
    endtask

    // ------------------------------------------------------------------
    // Sequence builders
    // ------------------------------------------------------------------

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
    endtask

    task automatic put_raw3(input logic [7:0] b, input logic [7:0] c, input logic [7:0] r);
        frame.push_back(CH_ESC);
        frame.push_back(CH_LBRACKET);
        frame.push_back(CH_UPPER_M);
        frame.push_back(b);
        frame.push_back(c);
        frame.push_back(r);
    endtask

    // UTF-8 encode v in len bytes; a len longer than needed gives an overlong form.
    task automatic put_utf8(input logic [20:0] v, input int len);
        case (len)
            1: frame.push_back({1'b0, v[6:0]});
            2: begin
                frame.push_back({3'b110, v[10:6]});
                frame.push_back({2'b10, v[5:0]});
            end
            3: begin
                frame.push_back({4'b1110, v[15:12]});
                frame.push_back({2'b10, v[11:6]});
                frame.push_back({2'b10, v[5:0]});
            end
            default: begin
                frame.push_back({5'b11110, v[20:18]});
                frame.push_back({2'b10, v[17:12]});
                frame.push_back({2'b10, v[11:6]});
                frame.push_back({2'b10, v[5:0]});
            end
        endcase
    endtask

    task automatic put_utf8_any(input logic [20:0] v);
        int shortest;
        shortest = (v < 21'd128) ? 1 : (v < 21'd2048) ? 2 : (v < 21'd65536) ? 3 : 4;
        put_utf8(v, $urandom_range(shortest, 4));
    endtask

    // Field value for the multibyte format, spread over every encoding length.
    function automatic logic [20:0] pick_wide(input int lo);
        case ($urandom_range(0, 3))
            0: return 21'($urandom_range(lo, 127));
            1: return 21'($urandom_range(lo, 2047));
            2: return 21'($urandom_range(lo, 65535));
            default: return 21'($urandom_range(lo, 21'h1FFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_raw_pos();
        return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(33, 255));
    endfunction

    // A decimal value: either a plain number or a run of up to seven digits that may wrap.
    task automatic put_decimal();
        int nd;
        if ($urandom_range(0, 1) == 0) begin
            put_text($sformatf("%0d", $urandom_range(0, 300)));
        end else begin
            nd = $urandom_range(1, 7);
            repeat (nd) frame.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // Append one random report in the given format, well-formed but for a decimal one with a lower-case end.
    task automatic put_report(input t_format f);
        case (f)
            FMT_DEFAULT: begin
                put_raw3(8'($urandom_range(32, 255)), pick_raw_pos(), pick_raw_pos());
            end
            FMT_UTF8: begin
                put_raw3(8'd0, 8'd0, 8'd0);
                repeat (3) void'(frame.pop_back());
                put_utf8_any(pick_wide(32));
                repeat (2) begin
                    if ($urandom_range(0, 7) == 0) put_utf8_any(21'd0);
                    else put_utf8_any(pick_wide(33));
                end
            end
            default: begin
                frame.push_back(CH_ESC);
                frame.push_back(CH_LBRACKET);
                if (f == FMT_SGR) frame.push_back(CH_LT);
                put_decimal();
                frame.push_back(CH_SEMI);
                put_decimal();
                frame.push_back(CH_SEMI);
                put_decimal();
                // Mostly press reports; an occasional lower-case end, which only
                // the sgr format takes as a release.
                frame.push_back(($urandom_range(0, 3) == 0) ? CH_LOWER_M : CH_UPPER_M);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default format: field extremes, zero substitution, a release, a motion
    // report with no button, and an ESC byte inside a report that restarts it.
    task automatic test_default_reports();
        frame = {};
        put_raw3(8'd32, 8'd0, 8'd0);
        put_raw3(8'd255, 8'd255, 8'd33);
        put_raw3(8'd35, 8'd34, 8'd34);
        put_raw3(8'h43, 8'd40, 8'd41);
        // Button byte ESC is below the offset, so it opens a new sequence,
        // which then dies on a column of exactly 32.
        put_text("\033[M");
        frame.push_back(CH_ESC);
        put_text("[M  ");
        put_raw3(8'd96, 8'd33, 8'd33);
        send_frame();
    endtask

    // Multibyte format: overlong zero, the widest 4-byte value, bad lead and
    // continuation bytes, and an ESC that ends one report and starts the next.
    task automatic test_utf8_reports();
        set_format(FMT_UTF8);
        frame = {};
        put_text("\033[M");
        put_utf8(21'd32, 1);
        put_utf8(21'd0, 2);
        put_utf8(21'h1FFFFF, 4);
        put_text("\033[M");
        put_utf8(21'hFFFF, 3);
        put_utf8(21'd33, 1);
        put_utf8(21'h7FF, 2);
        put_text("\033[M");
        frame.push_back(8'hF8);
        put_text("\033[M");
        frame.push_back(8'hC2);
        frame.push_back(8'h41);
        put_text("\033[M");
        frame.push_back(CH_ESC);
        put_text("[M !!");
        send_frame();
    endtask

    task automatic test_sgr_reports();
        set_format(FMT_SGR);
        frame = {};
        put_text("\033[<0;1;1M");
        put_text("\033[<65535;99999;0m");
        put_text("\033[<;1;1M");
        put_text("\033[<195;2;3m");
        put_text("\033[<35;7;8M");
        send_frame();
    endtask

    // Decimal format: the button offset wraps below 32, and a lower-case end
    // is not a terminator here.
    task automatic test_decimal_reports();
        set_format(FMT_DECIMAL);
        frame = {};
        put_text("\033[32;5;7M");
        put_text("\033[0;65536;1M");
        put_text("\033[35;1;1m");
        put_text("\033[96;200;300M");
        send_frame();
    endtask

    // Random traffic: several format phases, each with mostly well-formed
    // reports, some damaged or cut short, and some loose noise bytes.
    task automatic test_random_stream();
        int      p;
        int      kind;
        int      spot;
        t_format f;
        p = 0;
        while (bytes_sent < 560 || p < 4) begin
            f = (p < 4) ? t_format'(p) : t_format'($urandom_range(0, 3));
            set_format(f);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10)) begin
                frame = {};
                kind  = $urandom_range(0, 19);
                if (kind < 2) begin
                    repeat ($urandom_range(1, 6)) begin
                        frame.push_back(($urandom_range(0, 3) == 0) ? CH_ESC
                                                                    : 8'($urandom_range(0, 255)));
                    end
                end else begin
                    put_report(f);
                    spot = $urandom_range(0, frame.size() - 1);
                    if (kind < 5) begin
                        frame[spot] = 8'($urandom_range(0, 255));
                    end else if (kind < 7) begin
                        while (frame.size() > spot + 1) void'(frame.pop_back());
                    end
                end
                send_frame();
            end
            // Once in the run, the sender holds off mid-stream until the
            // block has handed out everything it owes.
            if (p == 2) wait_drained();
            p++;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Event side: pop with random stalls and check each event in order.
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [20:0] want_v,
                                        input logic [20:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endfunction

    initial begin : event_checker
        int           stall;
        t_mouse_event want;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_events.size() == 0) begin
                $display("%0t: event with nothing expected, button %0d column %0d line %0d",
                         $time, o_button, o_column, o_line);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("button", 21'(want.button), 21'(o_button));
                check_field("shift_key", 21'(want.shift_key), 21'(o_shift_key));
                check_field("alt_key", 21'(want.alt_key), 21'(o_alt_key));
                check_field("control_key", 21'(want.control_key), 21'(o_control_key));
                check_field("moving", 21'(want.moving), 21'(o_moving));
                check_field("release_res", 21'(want.release_res), 21'(o_release_res));
                check_field("held", 21'(want.held), 21'(o_held));
                check_field("column", want.column, o_column);
                check_field("line", want.line, o_line);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_byte_req  <= 8'd0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= FMT_DEFAULT;
        sel_format = FMT_DEFAULT;
        phase_q    = PH_IDLE;
        code_word  = '0;
        col_held   = '0;
        row_held   = '0;
        value_acc  = '0;
        cont_left  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_reports();
        test_utf8_reports();
        test_sgr_reports();
        test_decimal_reports();
        test_random_stream();
        // Finish on the two extremes of the format register.
        set_format(FMT_DECIMAL);
        frame = {};
        put_report(FMT_DECIMAL);
        send_frame();
        set_format(FMT_DEFAULT);
        frame = {};
        put_report(FMT_DEFAULT);
        send_frame();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
